FILE: hw/rtl/mct_pkg.sv
// Shared types and constants for the multiset counting table.
`timescale 1ns / 1ps

package mct_pkg;

	localparam int CAPACITY   = 64;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int USED_W     = $clog2(CAPACITY + 1);

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [KEY_BITS-1:0] key;
	} item_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] occurrences;
		logic [USED_W-1:0]     distinct_keys;
		logic [KEY_BITS-1:0]   popular_key;
		logic                  popular_valid;
		logic                  table_full;
	} result_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [COUNT_BITS-1:0] count;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic search;
		logic update;
		logic move_rd;
		logic move_wr;
		logic scan_clr;
		logic scan;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic search_done;
		logic need_move;
		logic scan_done;
	} sts_t;

endpackage

FILE: hw/rtl/mct_ctrl.sv
// Sequencing state machine for the multiset counting table.
`timescale 1ns / 1ps

module mct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output mct_pkg::ctl_t ctl,
	input  mct_pkg::sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SEARCH  = 7'b0000010,
		ST_UPDATE  = 7'b0000100,
		ST_MOVE_RD = 7'b0001000,
		ST_MOVE_WR = 7'b0010000,
		ST_SCAN    = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				ctl.search = 1'b1;
				if (sts.search_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				if (sts.need_move) begin
					state_d = ST_MOVE_RD;
				end else begin
					ctl.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_MOVE_RD: begin
				ctl.move_rd = 1'b1;
				state_d     = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				ctl.move_wr  = 1'b1;
				ctl.scan_clr = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

FILE: hw/rtl/mct_dpath.sv
// Entry memory, search and popularity scan datapath for the multiset table.
`timescale 1ns / 1ps

module mct_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  mct_pkg::item_t  item,
	input  mct_pkg::ctl_t   ctl,
	output mct_pkg::sts_t   sts,
	output mct_pkg::result_t result
);

	localparam int AW = mct_pkg::ADDR_W;
	localparam int UW = mct_pkg::USED_W;
	localparam int CW = mct_pkg::COUNT_BITS;
	localparam int KW = mct_pkg::KEY_BITS;
	localparam logic [UW-1:0] CAP_U = UW'(mct_pkg::CAPACITY);

	mct_pkg::entry_t mem_q [mct_pkg::CAPACITY];
	mct_pkg::entry_t rd_data_q;

	logic [1:0]    cmd_q;
	logic [KW-1:0] key_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] idx_q;
	logic [AW-1:0] cmp_idx_s1;
	logic          rd_vld_s1;
	logic          found_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] best_q;
	logic [KW-1:0] pop_key_q;
	logic [CW-1:0] occ_q;
	logic          full_q;

	logic            issue;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	mct_pkg::entry_t wr_data;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   cnt_dec;
	logic [UW-1:0]   used_last;

	assign used_last = used_q - UW'(1);
	assign cnt_inc   = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + CW'(1);
	assign cnt_dec   = cnt_q - CW'(1);

	assign issue = (ctl.search && !found_q && (idx_q < used_q)) ||
	               (ctl.scan && (idx_q < used_q));

	assign rd_addr = ctl.move_rd ? used_last[AW-1:0] : idx_q[AW-1:0];

	assign sts.search_done = found_q || ((idx_q == used_q) && !rd_vld_s1);
	assign sts.scan_done   = (idx_q == used_q) && !rd_vld_s1;
	assign sts.need_move   = (cmd_q == mct_pkg::CMD_REMOVE) && found_q &&
	                         (cnt_q == CW'(1));

	// write port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = '{key: key_q, count: cnt_inc};
		if (ctl.move_wr) begin
			wr_en   = 1'b1;
			wr_data = rd_data_q;
		end else if (ctl.update) begin
			case (cmd_q)
				mct_pkg::CMD_ADD: begin
					if (found_q) begin
						wr_en = 1'b1;
					end else if (used_q < CAP_U) begin
						wr_en   = 1'b1;
						wr_addr = used_q[AW-1:0];
						wr_data = '{key: key_q, count: CW'(1)};
					end
				end
				mct_pkg::CMD_REMOVE: begin
					if (found_q && (cnt_q != CW'(1))) begin
						wr_en   = 1'b1;
						wr_data = '{key: key_q, count: cnt_dec};
					end
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			// no read is issued in a load or scan-clear cycle
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + UW'(1);
			end
			if (ctl.load || ctl.scan_clr) begin
				idx_q <= '0;
			end
			if (ctl.load) begin
				found_q <= 1'b0;
				full_q  <= 1'b0;
			end else if (ctl.search && rd_vld_s1 && !found_q &&
			             (rd_data_q.key == key_q)) begin
				found_q <= 1'b1;
			end
			if (ctl.update && (cmd_q == mct_pkg::CMD_ADD) && !found_q) begin
				if (used_q < CAP_U) begin
					used_q <= used_q + UW'(1);
				end else begin
					full_q <= 1'b1;
				end
			end
			if (ctl.move_wr) begin
				used_q <= used_last;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			cmp_idx_s1 <= idx_q[AW-1:0];
		end
		if (ctl.load) begin
			cmd_q <= item.cmd;
			key_q <= item.key;
		end
		if (ctl.search && rd_vld_s1 && !found_q && (rd_data_q.key == key_q)) begin
			pos_q <= cmp_idx_s1;
			cnt_q <= rd_data_q.count;
		end
		if (ctl.update) begin
			case (cmd_q)
				mct_pkg::CMD_ADD: begin
					if (found_q) begin
						occ_q <= cnt_inc;
					end else if (used_q < CAP_U) begin
						occ_q <= CW'(1);
					end else begin
						occ_q <= '0;
					end
				end
				mct_pkg::CMD_REMOVE: begin
					occ_q <= found_q ? cnt_dec : '0;
				end
				default: begin
					occ_q <= found_q ? cnt_q : '0;
				end
			endcase
		end
		if (ctl.scan_clr) begin
			best_q    <= '0;
			pop_key_q <= '0;
		end else if (ctl.scan && rd_vld_s1 &&
		             ((cmp_idx_s1 == '0) || (rd_data_q.count > best_q))) begin
			best_q    <= rd_data_q.count;
			pop_key_q <= rd_data_q.key;
		end
	end

	assign result.occurrences   = occ_q;
	assign result.distinct_keys = used_q;
	assign result.popular_key   = pop_key_q;
	assign result.popular_valid = (used_q != '0);
	assign result.table_full    = full_q;

endmodule

FILE: hw/rtl/multiset_counting_table_unit.sv
// Top level of the multiset counting table: controller plus datapath.
`timescale 1ns / 1ps

// Multiset counting table: up to 64 distinct 32-bit keys, each with a 16-bit
// occurrence count held in a single-port-write entry memory.
// Input channel: drive item (cmd, key) and raise start; the item is taken at
// the rising edge where start is high and busy is low. busy stays high until
// the result has been shown.
// Result channel: done is high for exactly one cycle while result carries
// occurrences, distinct_keys, popular_key, popular_valid and table_full. The
// receiver cannot stall; it must take the result in that cycle.
// From the accepting edge to the end of the done cycle an item passes through
// a linear search at one entry per cycle over the keys held before the item,
// behind the read pipeline, the update state, the move read and move write
// states when a removal empties an entry and the last entry is moved into its
// slot, a second pass over the keys held after the update to find the most
// popular key, and the done state. The next item is taken no earlier than the
// edge after done; one item in flight.
// Reset empties the table at once (the key count drops to zero); memory
// contents are never read before they are written, so no clearing pass runs.

module multiset_counting_table_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mct_pkg::item_t   item,
	output logic             done,
	output mct_pkg::result_t result
);

	mct_pkg::ctl_t ctl;
	mct_pkg::sts_t sts;

	// sequencing: accept, search, update, optional move, scan, report
	mct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	// entry memory, counters and result registers
	mct_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.result (result)
	);

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the multiset counting table unit.
`timescale 1ns / 1ps

// Drive add, remove and query items into the table and check each result
// against a behavioral copy of the bag kept here.
// Run order:
//   - directed rows: empty-table queries and removes, first insertions, the
//     unused command code, removal that moves the last entry into the freed
//     slot, ties for most popular, filling to capacity and a refused add,
//     then draining back to empty
//   - random items in three idling phases: the sender holds start low with a
//     chance of 13 and then 63 percent, and then never. The result side has no
//     stall, so it gets no idling.
// Each expectation is queued when its item is accepted. The monitor compares
// every done strobe with the oldest expectation.
module tb_top;

	localparam int KW  = mct_pkg::KEY_BITS;
	localparam int CW  = mct_pkg::COUNT_BITS;
	localparam int UW  = mct_pkg::USED_W;
	localparam int CAP = mct_pkg::CAPACITY;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 72;	// a bit over capacity, so random adds can overflow
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 150;

	// One directed row: reps items, key advancing by key_step. Rows with
	// typed set carry a hand-written result; the rest go to the predictor.
	typedef struct packed {
		logic [1:0]       cmd;
		logic [KW-1:0]    key;
		logic [KW-1:0]    key_step;
		int               reps;
		bit               typed;
		mct_pkg::result_t want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	mct_pkg::item_t   item = '0;
	logic             done;
	mct_pkg::result_t result;

	// Predictor's copy of the bag.
	logic [KW-1:0] bag_keys[CAP];
	logic [CW-1:0] bag_counts[CAP];
	int            bag_used = 0;

	mct_pkg::result_t tally_q[$];
	row_t             rows[$];
	logic [KW-1:0]    key_pool[POOL_SIZE];
	int               idle_pct = 0;
	int               quiet_cycles = 0;
	bit               failed = 1'b0;

	multiset_counting_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one item to the predictor's bag and return the result it must give.
	function automatic mct_pkg::result_t bag_apply(input mct_pkg::item_t it);
		mct_pkg::result_t r;
		int               pos;
		logic [CW-1:0]    best;
		r = '0;
		// Scan backward so the lowest matching index wins.
		pos = bag_used;
		for (int i = bag_used - 1; i >= 0; i--)
			if (bag_keys[i] == it.key)
				pos = i;
		case (it.cmd)
			mct_pkg::CMD_ADD: begin
				if (pos < bag_used) begin
					// Hold the count at its maximum.
					if (bag_counts[pos] != {CW{1'b1}})
						bag_counts[pos] = bag_counts[pos] + CW'(1);
					r.occurrences = bag_counts[pos];
				end else if (bag_used < CAP) begin
					bag_keys[bag_used] = it.key;
					bag_counts[bag_used] = CW'(1);
					bag_used++;
					r.occurrences = CW'(1);
				end else begin
					r.table_full = 1'b1;
				end
			end
			mct_pkg::CMD_REMOVE: begin
				if (pos < bag_used) begin
					bag_counts[pos] = bag_counts[pos] - CW'(1);
					if (bag_counts[pos] == '0) begin
						// Move the last entry into the emptied slot and shrink.
						bag_keys[pos] = bag_keys[bag_used - 1];
						bag_counts[pos] = bag_counts[bag_used - 1];
						bag_used--;
					end else begin
						r.occurrences = bag_counts[pos];
					end
				end
			end
			default: begin
				// Query, and the unused code that acts as one.
				if (pos < bag_used)
					r.occurrences = bag_counts[pos];
			end
		endcase
		r.distinct_keys = UW'(bag_used);
		if (bag_used > 0) begin
			// First entry holding the highest count wins ties.
			best = bag_counts[0];
			r.popular_key = bag_keys[0];
			r.popular_valid = 1'b1;
			for (int i = 1; i < bag_used; i++)
				if (bag_counts[i] > best) begin
					best = bag_counts[i];
					r.popular_key = bag_keys[i];
				end
		end
		return r;
	endfunction

	function automatic mct_pkg::result_t tally(input int occ, input int n_keys,
			input logic [KW-1:0] pop, input int valid, input int full);
		mct_pkg::result_t r;
		r.occurrences = CW'(occ);
		r.distinct_keys = UW'(n_keys);
		r.popular_key = pop;
		r.popular_valid = (valid != 0);
		r.table_full = (full != 0);
		return r;
	endfunction

	task automatic sweep(input logic [1:0] cmd, input logic [KW-1:0] key,
			input logic [KW-1:0] key_step, input int reps);
		row_t r;
		r = '0;
		r.cmd = cmd;
		r.key = key;
		r.key_step = key_step;
		r.reps = reps;
		rows.push_back(r);
	endtask

	task automatic known(input logic [1:0] cmd, input logic [KW-1:0] key,
			input mct_pkg::result_t want);
		row_t r;
		r = '0;
		r.cmd = cmd;
		r.key = key;
		r.reps = 1;
		r.typed = 1'b1;
		r.want = want;
		rows.push_back(r);
	endtask

	// Present one item, wait for it to be taken and queue its expectation.
	// Each cycle the sender idles with probability idle_pct percent; the item
	// stays on the ports until taken. Leave start as it is on return; the next
	// call drives a new item in the same step.
	task automatic issue(input mct_pkg::item_t it, input bit typed,
			input mct_pkg::result_t want);
		mct_pkg::result_t guess;
		bit               taken;
		item <= it;
		start <= ($urandom_range(99) >= idle_pct);
		do begin
			@(posedge clk);
			taken = start && !busy;
			if (!taken)
				start <= ($urandom_range(99) >= idle_pct);
		end while (!taken);
		guess = bag_apply(it);
		tally_q.push_back(typed ? want : guess);
	endtask

	task automatic walk_rows(input int first, input int last);
		mct_pkg::item_t it;
		for (int n = first; n < last; n++)
			for (int k = 0; k < rows[n].reps; k++) begin
				it.cmd = rows[n].cmd;
				it.key = rows[n].key + KW'(k) * rows[n].key_step;
				issue(it, rows[n].typed, rows[n].want);
			end
	endtask

	// Random items in alternating grow and shrink stretches, so the table
	// swings between empty and full. Removes and queries mostly name keys
	// that are present; a tenth of all keys are fully random.
	task automatic random_items(input int count);
		mct_pkg::item_t it;
		bit             growing;
		int             stretch;
		int             roll;
		growing = ($urandom_range(1) != 0);
		stretch = $urandom_range(80, 200);
		for (int n = 0; n < count; n++) begin
			if (--stretch == 0) begin
				growing = !growing;
				stretch = $urandom_range(80, 200);
			end
			roll = $urandom_range(99);
			if (roll < (growing ? 70 : 15))
				it.cmd = mct_pkg::CMD_ADD;
			else if (roll < (growing ? 85 : 80))
				it.cmd = mct_pkg::CMD_REMOVE;
			else if (roll < 96)
				it.cmd = mct_pkg::CMD_QUERY;
			else
				it.cmd = CMD_UNUSED;
			roll = $urandom_range(9);
			if (roll == 0)
				it.key = $urandom;
			else if (roll < 7 && it.cmd != mct_pkg::CMD_ADD && bag_used > 0)
				it.key = bag_keys[$urandom_range(bag_used - 1)];
			else
				it.key = key_pool[$urandom_range(POOL_SIZE - 1)];
			issue(it, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [KW-1:0] want,
			input logic [KW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Compare every result with the oldest expectation.
	always @(posedge clk) begin
		mct_pkg::result_t want;
		if (arst_n && done) begin
			if (tally_q.size() == 0) begin
				$error("result with no item outstanding: %p", result);
				failed = 1'b1;
			end else begin
				want = tally_q.pop_front();
				check_field("occurrences", KW'(want.occurrences),
					KW'(result.occurrences));
				check_field("distinct_keys", KW'(want.distinct_keys),
					KW'(result.distinct_keys));
				check_field("popular_key", want.popular_key, result.popular_key);
				check_field("popular_valid", KW'(want.popular_valid),
					KW'(result.popular_valid));
				check_field("table_full", KW'(want.table_full),
					KW'(result.table_full));
			end
		end
	end

	// Stop a hung run: count cycles in which neither an item nor a result moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("multiset_counting_table_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Directed rows, starting from the empty table after reset.
		known(mct_pkg::CMD_QUERY, 32'h0000_0000, tally(0, 0, 0, 0, 0));
		known(mct_pkg::CMD_REMOVE, 32'hFFFF_FFFF, tally(0, 0, 0, 0, 0));
		known(mct_pkg::CMD_ADD, 32'h0000_0000, tally(1, 1, 32'h0000_0000, 1, 0));
		known(mct_pkg::CMD_ADD, 32'hFFFF_FFFF, tally(1, 2, 32'h0000_0000, 1, 0));
		known(mct_pkg::CMD_ADD, 32'hFFFF_FFFF, tally(2, 2, 32'hFFFF_FFFF, 1, 0));
		known(CMD_UNUSED, 32'hFFFF_FFFF, tally(2, 2, 32'hFFFF_FFFF, 1, 0));
		// Last entry moves into slot zero.
		known(mct_pkg::CMD_REMOVE, 32'h0000_0000, tally(0, 1, 32'hFFFF_FFFF, 1, 0));
		known(mct_pkg::CMD_REMOVE, 32'hFFFF_FFFF, tally(1, 1, 32'hFFFF_FFFF, 1, 0));
		known(mct_pkg::CMD_REMOVE, 32'hFFFF_FFFF, tally(0, 0, 32'h0000_0000, 0, 0));
		// Tie on the highest count goes to the earlier entry.
		sweep(mct_pkg::CMD_ADD, 32'hA5A5_A5A5, 0, 1);
		sweep(mct_pkg::CMD_ADD, 32'h5A5A_5A5A, 0, 2);
		known(mct_pkg::CMD_ADD, 32'hA5A5_A5A5, tally(2, 2, 32'hA5A5_A5A5, 1, 0));
		sweep(mct_pkg::CMD_REMOVE, 32'h5A5A_5A5A, 0, 1);
		sweep(mct_pkg::CMD_REMOVE, 32'h1234_5678, 0, 1);
		// Fill to capacity, then get refused.
		sweep(mct_pkg::CMD_ADD, 32'h0001_0000, 32'h0101_0101, CAP - 2);
		known(mct_pkg::CMD_ADD, 32'hDEAD_BEEF, tally(0, CAP, 32'hA5A5_A5A5, 1, 1));
		sweep(mct_pkg::CMD_ADD, 32'h0001_0000, 0, 1);
		sweep(mct_pkg::CMD_REMOVE, 32'h0001_0000, 32'h0101_0101, CAP - 2);
		sweep(mct_pkg::CMD_REMOVE, 32'h0001_0000, 0, 1);
		sweep(mct_pkg::CMD_REMOVE, 32'hA5A5_A5A5, 0, 2);
		known(mct_pkg::CMD_REMOVE, 32'h5A5A_5A5A, tally(0, 0, 32'h0000_0000, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 13;
		walk_rows(0, rows.size());
		random_items(500);
		idle_pct = 63;
		random_items(500);
		idle_pct = 0;
		random_items(500);
		start <= 1'b0;

		// Let the last results arrive, then watch for strays.
		while (tally_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed)
			$display("multiset_counting_table_unit test passed");
		else
			$display("multiset_counting_table_unit test failed");
		$finish;
	end

endmodule
